/* design/tspb_pkg.sv */
// shared constants and types for the two-wire slave packet buffer
`timescale 1ns / 1ps
`default_nettype none
package tspb_pkg;

   localparam int BUFFER_DEPTH = 4;
   localparam int IDX_W = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
   // width that holds index + 1 and the payload size alike
   localparam int CMP_W = (IDX_W + 1 > 3) ? IDX_W + 1 : 3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [3:0] {
      KIND_TX_ACK     = 4'd0,
      KIND_TX_NACK    = 4'd1,
      KIND_RX_ADDR    = 4'd2,
      KIND_RX_DATA    = 4'd3,
      KIND_STOP       = 4'd4,
      KIND_ABORT      = 4'd5,
      KIND_OTHER      = 4'd6,
      KIND_HOST_CLEAR = 4'd7,
      KIND_HOST_ACC   = 4'd8
   } kind_type;

   localparam logic REG_INIT_CODE    = 1'b0;
   localparam logic REG_PAYLOAD_SIZE = 1'b1;

   typedef struct packed {
      logic [7:0] init_code;
      logic [2:0] payload_size;
   } cfg_type;

   // item metadata waiting for the buffer read data
   typedef struct packed {
      logic tx_sel;
      logic hd_sel;
      logic action;
      logic busy;
      logic ready;
   } meta_type;

endpackage
`default_nettype wire

/* design/twi_slave_packet_buffer.sv */
// two-wire slave response logic with circular packet buffer, top level
// each request beat passes through the stage-one register and then the output register
// throughput: one beat per cycle while the result output is not stalled
// a request is still taken while one finished result waits at the output
// reset: synchronous, clears index, flags, pipeline valids and init code; payload size resets to 4
// buffer contents are not cleared and are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module twi_slave_packet_buffer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rx_byte[7:0], host_index[9:8], host_write[10], zero pad
   input  wire logic [tspb_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[3:0]
   input  wire logic [3:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tx_byte[7:0], bus_action[8], busy_res[9], packet_ready[10], host_data[18:11], zero pad
   output logic [tspb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [2:0]                      csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import tspb_pkg::*;

   logic [7:0] init_code_ff;
   logic [2:0] payload_size_ff;
   cfg_type    cfg;
   logic       csr_wr;

   logic       accept, s1_valid, s1_take;
   meta_type   s1_meta;
   logic [7:0] rd_data;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_code_ff    <= 8'd0;
         payload_size_ff <= 3'd4;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_INIT_CODE:    init_code_ff    <= csr_pwdata[7:0];
            REG_PAYLOAD_SIZE: payload_size_ff <= csr_pwdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_INIT_CODE:    csr_prdata = {24'd0, init_code_ff};
         REG_PAYLOAD_SIZE: csr_prdata = {29'd0, payload_size_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.init_code    = init_code_ff;
   assign cfg.payload_size = payload_size_ff;

   // stage one drains into the output register whenever that frees up
   assign s1_take    = s1_valid & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid | s1_take;
   assign accept     = req_tvalid & req_tready;

   tspb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .host_index (req_tdata[9:8]),
      .host_write (req_tdata[10]),
      .cfg        (cfg),
      .s1_take    (s1_take),
      .s1_valid   (s1_valid),
      .s1_meta    (s1_meta),
      .rd_data    (rd_data)
   );

   always_comb begin
      out_data_in = {5'd0,
                     (s1_meta.hd_sel ? rd_data : 8'd0),
                     s1_meta.ready,
                     s1_meta.busy,
                     s1_meta.action,
                     (s1_meta.tx_sel ? rd_data : 8'd0)};
      out_valid_in = s1_take | (out_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

/* design/tspb_ram.sv */
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module tspb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                                      clock,
   input  wire logic                                      we,
   input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                          wdata,
   input  wire logic                                      re,
   input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

/* design/tspb_ctrl.sv */
// event decode, flag and index update, buffer access issue stage
`timescale 1ns / 1ps
`default_nettype none
module tspb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [3:0]        kind,
   input  wire logic [7:0]        rx_byte,
   input  wire logic [1:0]        host_index,
   input  wire logic              host_write,
   input  wire tspb_pkg::cfg_type cfg,
   input  wire logic              s1_take,
   output logic                   s1_valid,
   output tspb_pkg::meta_type     s1_meta,
   output logic [7:0]             rd_data
);
   import tspb_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             expect_ff, expect_in;
   logic             busy_ff, busy_in;
   logic             ready_ff, ready_in;
   logic             s1_valid_ff, s1_valid_in;
   meta_type         meta_ff, meta_in;

   logic             we, re;
   logic [IDX_W-1:0] waddr, raddr, hidx, idx_next;
   logic             hidx_ok;
   logic [CMP_W-1:0] idx_plus;

   assign hidx     = IDX_W'(host_index);
   assign hidx_ok  = 32'(host_index) < BUFFER_DEPTH;
   assign idx_next = (32'(idx_ff) == BUFFER_DEPTH - 1) ? '0 : idx_ff + 1'b1;
   assign idx_plus = CMP_W'(idx_ff) + 1'b1;

   always_comb begin
      idx_in    = idx_ff;
      expect_in = expect_ff;
      busy_in   = busy_ff;
      ready_in  = ready_ff;
      we        = 1'b0;
      re        = 1'b0;
      waddr     = idx_ff;
      raddr     = idx_ff;
      meta_in   = '0;
      case (kind)
         KIND_TX_ACK: begin
            re             = accept;
            meta_in.tx_sel = 1'b1;
            idx_in         = idx_next;
            busy_in        = 1'b1;
         end
         KIND_TX_NACK, KIND_STOP, KIND_OTHER: begin
            busy_in = 1'b0;
         end
         KIND_RX_ADDR: begin
            expect_in = 1'b1;
            busy_in   = 1'b1;
         end
         KIND_RX_DATA: begin
            if (expect_ff) begin
               expect_in = 1'b0;
               if (rx_byte == cfg.init_code) begin
                  idx_in   = '0;
                  ready_in = 1'b0;
               end
            end else begin
               we = accept;
               if (idx_plus >= CMP_W'(cfg.payload_size)) begin
                  ready_in = 1'b1;
               end
               idx_in = idx_next;
            end
            busy_in = 1'b1;
         end
         KIND_ABORT: begin
            meta_in.action = 1'b1;
            busy_in        = 1'b0;
         end
         KIND_HOST_CLEAR: begin
            ready_in = 1'b0;
         end
         KIND_HOST_ACC: begin
            waddr = hidx;
            raddr = hidx;
            if (hidx_ok) begin
               if (host_write) begin
                  we = accept;
               end else begin
                  re             = accept;
                  meta_in.hd_sel = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      meta_in.busy  = busy_in;
      meta_in.ready = ready_in & busy_in;
      s1_valid_in   = accept | (s1_valid_ff & ~s1_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         expect_ff   <= 1'b0;
         busy_ff     <= 1'b0;
         ready_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            idx_ff    <= idx_in;
            expect_ff <= expect_in;
            busy_ff   <= busy_in;
            ready_ff  <= ready_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

   // reads and writes land at the accept edge, so the next beat sees the update
   tspb_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (rx_byte),
      .re    (re),
      .raddr (raddr),
      .rdata (rd_data)
   );

   assign s1_valid = s1_valid_ff;
   assign s1_meta  = meta_ff;

endmodule
`default_nettype wire

/* design/tspb_checker.sv */
// port-level assertions for the packet buffer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tspb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // packet ready is only reported while busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9])
      else $error("packet ready without busy");

   // stop-and-disable always drops busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> !rsp_tdata[9])
      else $error("bus stop with busy set");

   // a beat never carries both a transmit byte and host read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == 8'd0) || (rsp_tdata[18:11] == 8'd0))
      else $error("tx byte and host data both set");

endmodule

bind twi_slave_packet_buffer tspb_checker u_tspb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
